// File: design/ase_pkg.sv
// Shared types, codes and constants for the ARM subset instruction executor.
package ase_pkg;

  localparam int WORD_BITS     = 32;
  localparam int ADDR_BITS_DEF = 26;
  localparam int FETCH_BITS    = 26;
  localparam int RF_DEPTH      = 15;
  localparam int RF_AW         = 4;

  // Register numbers with a fixed role
  localparam logic [3:0] REG_PC   = 4'd15;
  localparam logic [3:0] REG_LINK = 4'd14;
  localparam logic [3:0] REG_CHAR = 4'd0;
  localparam logic [3:0] REG_EXIT = 4'd2;

  // Condition codes
  localparam logic [3:0] COND_EQ = 4'h0;
  localparam logic [3:0] COND_NE = 4'h1;
  localparam logic [3:0] COND_AL = 4'he;
  localparam logic [3:0] COND_NV = 4'hf;

  // Instruction classes
  localparam logic [2:0] CLS_DP_REG = 3'h0;
  localparam logic [2:0] CLS_DP_IMM = 3'h1;
  localparam logic [2:0] CLS_BRANCH = 3'h5;
  localparam logic [3:0] CLS_SWI    = 4'hf;

  // Data processing opcodes
  localparam logic [3:0] OPC_MOV = 4'hd;
  localparam logic [3:0] OPC_CMP = 4'ha;
  localparam logic [3:0] OPC_ADD = 4'h4;
  localparam logic [3:0] OPC_SUB = 4'h2;

  localparam logic [1:0] SHIFT_LSL = 2'h0;

  // Software interrupt numbers
  localparam logic [23:0] SWI_WRCH    = 24'h000000;
  localparam logic [23:0] SWI_NEWLINE = 24'h000003;
  localparam logic [23:0] SWI_EXIT    = 24'h000011;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0a;

  typedef enum logic [3:0] {
    ST_EXEC     = 4'd0,
    ST_SKIP     = 4'd1,
    ST_EXIT     = 4'd2,
    ST_BADCOND  = 4'd3,
    ST_BADSWI   = 4'd4,
    ST_BADSHIFT = 4'd5,
    ST_BADOP    = 4'd6,
    ST_BADINSTR = 4'd7,
    ST_ZERO     = 4'd8,
    ST_HALTED   = 4'd9
  } status_t;

  typedef struct packed {
    logic             en;
    logic [RF_AW-1:0] addr_a;
    logic [RF_AW-1:0] addr_b;
  } rf_rd_t;

  typedef struct packed {
    logic                 en;
    logic [RF_AW-1:0]     addr;
    logic [WORD_BITS-1:0] data;
  } rf_wr_t;

endpackage

// File: design/ase_regfile.sv
// Register file r0-r14: synchronous two-read one-write memory with forwarding.
module ase_regfile #(
  parameter int DEPTH = ase_pkg::RF_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ase_pkg::rf_rd_t                rd,
  input  ase_pkg::rf_wr_t                wr,
  output logic [ase_pkg::WORD_BITS-1:0]  rd_data_a,
  output logic [ase_pkg::WORD_BITS-1:0]  rd_data_b
);
  import ase_pkg::*;

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]     vld;
  logic [WORD_BITS-1:0] mem_a;
  logic [WORD_BITS-1:0] mem_b;
  logic                 vld_a;
  logic                 vld_b;
  logic [RF_AW-1:0]     addr_a_q;
  logic [RF_AW-1:0]     addr_b_q;
  rf_wr_t               last_wr;

  // Write port and registered reads (read sees the old entry)
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      mem_a    <= mem[rd.addr_a];
      mem_b    <= mem[rd.addr_b];
      addr_a_q <= rd.addr_a;
      addr_b_q <= rd.addr_b;
    end
  end

  // Track written entries so that never-written ones read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld          <= '0;
      vld_a        <= 1'b0;
      vld_b        <= 1'b0;
      last_wr.en   <= 1'b0;
      last_wr.addr <= '0;
      last_wr.data <= '0;
    end else begin
      if (wr.en) begin
        vld[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        vld_a <= vld[rd.addr_a];
        vld_b <= vld[rd.addr_b];
      end
      last_wr <= wr.en ? wr : last_wr;
    end
  end

  // Forward the most recent write over a stale read
  always_comb begin
    if (last_wr.en && last_wr.addr == addr_a_q) begin
      rd_data_a = last_wr.data;
    end else begin
      rd_data_a = vld_a ? mem_a : '0;
    end
    if (last_wr.en && last_wr.addr == addr_b_q) begin
      rd_data_b = last_wr.data;
    end else begin
      rd_data_b = vld_b ? mem_b : '0;
    end
  end

endmodule

// File: design/arm_subset_instruction_executor.sv
// Top level: ARM subset executor, register read stage, execute stage and result register.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  in      | in_valid / in_stall  | instruction_word
//  out     | out_valid / out_stall| next_fetch_address, char_valid, char_value,
//          |                      | exit_code, status
//
// One instruction per cycle while out_stall does not hold the result. A beat is
// accepted into the read stage, where the register file read is issued; once the result
// register is free, the execute stage executes it and writes the register file, r15 and
// the halt flag, and loads the result register. A write followed at once by a read of
// the same register is forwarded. Reset clears all registers to zero and the halt flag.
// out_stall holds the result register and then the execute stage, then in_stall.
module arm_subset_instruction_executor #(
  parameter int ADDRESS_BITS = ase_pkg::ADDR_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ase_pkg::WORD_BITS-1:0]   instruction_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ase_pkg::FETCH_BITS-1:0]  next_fetch_address,
  output logic                            char_valid,
  output logic [7:0]                      char_value,
  output logic [7:0]                      exit_code,
  output logic [3:0]                      status
);
  import ase_pkg::*;

  logic                 s1_valid;
  logic [WORD_BITS-1:0] s1_ins;
  logic                 s1_fire;
  logic                 in_accept;

  logic [WORD_BITS-1:0] pc;
  logic [WORD_BITS-1:0] pc_next;
  logic                 halted;
  logic                 halted_next;

  rf_rd_t               rf_rd;
  rf_wr_t               rf_wr;
  rf_wr_t               wr_c;
  logic [WORD_BITS-1:0] rdata_a;
  logic [WORD_BITS-1:0] rdata_b;

  logic [RF_AW-1:0]     rd_a_sel;
  logic [RF_AW-1:0]     rd_b_sel;

  status_t              st;
  logic                 cvalid;
  logic [7:0]           cval;
  logic [7:0]           ecode;

  // Decode fields
  logic [3:0]           cond;
  logic [3:0]           opc;
  logic [3:0]           rd_idx;
  logic [3:0]           rn_idx;
  logic [3:0]           rm_idx;
  logic [WORD_BITS-1:0] pc4;
  logic [WORD_BITS-1:0] rn_val;
  logic [WORD_BITS-1:0] rm_val;
  logic [WORD_BITS-1:0] imm_val;
  logic [2*WORD_BITS-1:0] imm_dbl;
  logic [WORD_BITS-1:0] op2;
  logic [WORD_BITS-1:0] alu_sum;
  logic [WORD_BITS-1:0] alu_diff;
  logic [WORD_BITS-1:0] dp_val;
  logic [WORD_BITS-1:0] br_off;
  logic                 run;
  logic                 chk;
  logic                 ok;

  // Handshake: the execute stage moves when the result register is free
  assign s1_fire   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !s1_fire;
  assign in_accept = in_valid && !in_stall;

  // Register read addresses straight from the incoming beat; r15 is not in memory
  always_comb begin
    if (instruction_word[27:24] == CLS_SWI) begin
      rd_a_sel = (instruction_word[23:0] == SWI_EXIT) ? REG_EXIT : REG_CHAR;
    end else begin
      rd_a_sel = instruction_word[19:16];
    end
    rd_b_sel = instruction_word[3:0];
    if (rd_a_sel == REG_PC) begin
      rd_a_sel = '0;
    end
    if (rd_b_sel == REG_PC) begin
      rd_b_sel = '0;
    end
    rf_rd.en     = in_accept;
    rf_rd.addr_a = rd_a_sel;
    rf_rd.addr_b = rd_b_sel;
  end

  ase_regfile #(
    .DEPTH (RF_DEPTH)
  ) u_regfile (
    .clk       (clk),
    .rst       (rst),
    .rd        (rf_rd),
    .wr        (rf_wr),
    .rd_data_a (rdata_a),
    .rd_data_b (rdata_b)
  );

  // Operands and ALU
  assign cond     = s1_ins[31:28];
  assign opc      = s1_ins[24:21];
  assign rn_idx   = s1_ins[19:16];
  assign rd_idx   = s1_ins[15:12];
  assign rm_idx   = s1_ins[3:0];
  assign pc4      = pc + WORD_BITS'(4);
  assign rn_val   = (rn_idx == REG_PC) ? pc4 : rdata_a;
  assign rm_val   = (rm_idx == REG_PC) ? pc4 : rdata_b;
  assign imm_dbl  = {24'b0, s1_ins[7:0], 24'b0, s1_ins[7:0]} >> {s1_ins[11:8], 1'b0};
  assign imm_val  = imm_dbl[WORD_BITS-1:0];
  assign op2      = (s1_ins[27:25] == CLS_DP_IMM) ? imm_val : (rm_val << s1_ins[11:7]);
  assign alu_sum  = rn_val + op2;
  assign alu_diff = rn_val - op2;
  assign br_off   = {{6{s1_ins[23]}}, s1_ins[23:0], 2'b00};

  // Execute: condition, class decode, state updates and result fields
  always_comb begin
    pc_next     = pc;
    halted_next = halted;
    st          = ST_EXEC;
    cvalid      = 1'b0;
    cval        = '0;
    ecode       = '0;
    wr_c.en     = 1'b0;
    wr_c.addr   = rd_idx;
    wr_c.data   = '0;
    run         = 1'b0;
    chk         = 1'b0;
    ok          = 1'b1;
    dp_val      = op2;

    if (halted) begin
      st = ST_HALTED;
    end else begin
      pc_next = pc4;
      case (cond)
        COND_NV: begin
          st = ST_SKIP;
        end
        COND_AL: begin
          run = 1'b1;
        end
        COND_NE: begin
          run = !pc4[30];
          if (!run) st = ST_SKIP;
        end
        COND_EQ: begin
          run = pc4[30];
          if (!run) st = ST_SKIP;
        end
        default: begin
          st = ST_BADCOND;
        end
      endcase

      if (run) begin
        chk = 1'b1;
        if (s1_ins[27:25] == CLS_BRANCH) begin
          if (s1_ins[24]) begin
            wr_c.en   = 1'b1;
            wr_c.addr = REG_LINK;
            wr_c.data = {6'b0, pc4[25:0]};
          end
          pc_next = pc4 + br_off + WORD_BITS'(4);
        end else if (s1_ins[27:24] == CLS_SWI) begin
          case (s1_ins[23:0])
            SWI_WRCH: begin
              cvalid = 1'b1;
              cval   = rdata_a[7:0];
            end
            SWI_NEWLINE: begin
              cvalid = 1'b1;
              cval   = CHAR_NEWLINE;
            end
            SWI_EXIT: begin
              st    = ST_EXIT;
              ecode = rdata_a[7:0];
              chk   = 1'b0;
            end
            default: begin
              st  = ST_BADSWI;
              chk = 1'b0;
            end
          endcase
        end else if (s1_ins[27:25] == CLS_DP_REG || s1_ins[27:25] == CLS_DP_IMM) begin
          if (s1_ins[27:25] == CLS_DP_REG && s1_ins[6:5] != SHIFT_LSL) begin
            st = ST_BADSHIFT;
            ok = 1'b0;
          end else begin
            case (opc)
              OPC_MOV: dp_val = op2;
              OPC_ADD: dp_val = alu_sum;
              OPC_SUB: dp_val = alu_diff;
              OPC_CMP: begin
                pc_next = {alu_diff[31], !alu_diff[31] && (alu_diff == '0), 2'b00,
                           pc4[27:0]};
              end
              default: begin
                st = ST_BADOP;
                ok = 1'b0;
              end
            endcase
            if (ok && opc != OPC_CMP) begin
              if (rd_idx == REG_PC) begin
                pc_next = dp_val;
              end else begin
                wr_c.en   = 1'b1;
                wr_c.data = dp_val;
              end
            end
          end
          if (!ok) chk = 1'b0;
        end else begin
          st  = ST_BADINSTR;
          chk = 1'b0;
        end
      end

      if (chk && pc_next == '0) begin
        st = ST_ZERO;
      end
      if (st inside {[ST_EXIT:ST_ZERO]}) begin
        halted_next = 1'b1;
      end
    end
  end

  // Commit the register file write only when the execute stage moves
  always_comb begin
    rf_wr      = wr_c;
    rf_wr.en   = wr_c.en && s1_fire;
  end

  // Control state: stage valids, r15 and halt flag
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      pc        <= '0;
      halted    <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        out_valid <= 1'b1;
        pc        <= pc_next;
        halted    <= halted_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: hold the instruction and the result beat
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_ins <= instruction_word;
    end
    if (s1_fire) begin
      next_fetch_address <= FETCH_BITS'(pc_next[ADDRESS_BITS-1:0]);
      char_valid         <= cvalid;
      char_value         <= cval;
      exit_code          <= ecode;
      status             <= st;
    end
  end

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the ARM subset instruction executor.
`timescale 1ns / 100ps

module tb_top;
  import ase_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  // Architectural state tracked alongside the core
  typedef struct packed {
    logic [14:0][31:0] gpr;
    logic [31:0]       r15;
    logic              halted;
  } core_t;

  // One expected result beat
  typedef struct packed {
    logic [FETCH_BITS-1:0] fetch_addr;
    logic                  chr_valid;
    logic [7:0]            chr;
    logic [7:0]            exit_val;
    status_t               st;
  } result_t;

  typedef enum int {
    FLT_EXIT, FLT_BAD_COND, FLT_BAD_SWI, FLT_BAD_SHIFT,
    FLT_BAD_OP, FLT_BAD_INSTR, FLT_PC_ZERO, FLT_PC_WRAP_CHAR
  } fault_kind_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [WORD_BITS-1:0]   instruction_word = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [FETCH_BITS-1:0]  next_fetch_address;
  logic                   char_valid;
  logic [7:0]             char_value;
  logic [7:0]             exit_code;
  logic [3:0]             status;

  core_t   arch_state = '0;
  result_t pending_results[$];
  int      error_count = 0;
  int      idle_cycles = 0;
  int      in_idle_pct = 0;
  int      out_stall_pct = 0;

  arm_subset_instruction_executor dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .instruction_word   (instruction_word),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .next_fetch_address (next_fetch_address),
    .char_valid         (char_valid),
    .char_value         (char_value),
    .exit_code          (exit_code),
    .status             (status)
  );

  always #10 clk = ~clk;

  // Instruction encoders
  function automatic logic [31:0] enc_dp_imm(input logic [3:0] cond, input logic [3:0] opc,
                                             input logic [3:0] rd, input logic [3:0] rn,
                                             input logic [3:0] rot, input logic [7:0] imm);
    return {cond, CLS_DP_IMM, opc, 1'b0, rn, rd, rot, imm};
  endfunction

  function automatic logic [31:0] enc_dp_reg(input logic [3:0] cond, input logic [3:0] opc,
                                             input logic [3:0] rd, input logic [3:0] rn,
                                             input logic [4:0] amt, input logic [1:0] styp,
                                             input logic b4, input logic [3:0] rm);
    return {cond, CLS_DP_REG, opc, 1'b0, rn, rd, amt, styp, b4, rm};
  endfunction

  function automatic logic [31:0] enc_branch(input logic [3:0] cond, input logic link,
                                             input logic [23:0] off);
    return {cond, CLS_BRANCH, link, off};
  endfunction

  function automatic logic [31:0] enc_swi(input logic [3:0] cond, input logic [23:0] num);
    return {cond, CLS_SWI, num};
  endfunction

  function automatic logic [31:0] read_arch_reg(input core_t c, input logic [3:0] idx);
    return (idx == REG_PC) ? c.r15 : c.gpr[idx];
  endfunction

  // Execute one instruction on the tracked state and return the result it reports
  function automatic result_t execute_instr(input logic [31:0] w, inout core_t c);
    result_t     r;
    logic        run, zero_check, ok;
    logic [31:0] op2, val, diff;
    logic [63:0] rot_pair;
    logic [3:0]  rd;
    r = '0;
    r.st = ST_EXEC;
    run = 1'b0;
    zero_check = 1'b0;
    if (c.halted) begin
      r.st = ST_HALTED;
    end else begin
      c.r15 = c.r15 + 32'd4;
      case (w[31:28])
        COND_NV: r.st = ST_SKIP;
        COND_AL: run = 1'b1;
        COND_NE: begin
          run = !c.r15[30];
          if (!run) r.st = ST_SKIP;
        end
        COND_EQ: begin
          run = c.r15[30];
          if (!run) r.st = ST_SKIP;
        end
        default: r.st = ST_BADCOND;
      endcase

      if (run) begin
        zero_check = 1'b1;
        if (w[27:25] == CLS_BRANCH) begin
          // link gets the advanced pc, target is relative to pc + 4
          if (w[24]) c.gpr[REG_LINK] = {6'b0, c.r15[25:0]};
          c.r15 = c.r15 + {{6{w[23]}}, w[23:0], 2'b00} + 32'd4;
        end else if (w[27:24] == CLS_SWI) begin
          case (w[23:0])
            SWI_WRCH: begin
              r.chr_valid = 1'b1;
              r.chr = c.gpr[REG_CHAR][7:0];
            end
            SWI_NEWLINE: begin
              r.chr_valid = 1'b1;
              r.chr = CHAR_NEWLINE;
            end
            SWI_EXIT: begin
              r.st = ST_EXIT;
              r.exit_val = c.gpr[REG_EXIT][7:0];
              zero_check = 1'b0;
            end
            default: begin
              r.st = ST_BADSWI;
              zero_check = 1'b0;
            end
          endcase
        end else if (w[27:25] == CLS_DP_REG || w[27:25] == CLS_DP_IMM) begin
          ok = 1'b1;
          op2 = '0;
          rd = w[15:12];
          if (w[27:25] == CLS_DP_IMM) begin
            rot_pair = {24'b0, w[7:0], 24'b0, w[7:0]} >> {w[11:8], 1'b0};
            op2 = rot_pair[31:0];
          end else if (w[6:5] == SHIFT_LSL) begin
            op2 = read_arch_reg(c, w[3:0]) << w[11:7];
          end else begin
            r.st = ST_BADSHIFT;
            ok = 1'b0;
          end
          if (ok) begin
            case (w[24:21])
              OPC_MOV: val = op2;
              OPC_ADD: val = read_arch_reg(c, w[19:16]) + op2;
              OPC_SUB: val = read_arch_reg(c, w[19:16]) - op2;
              OPC_CMP: begin
                diff = read_arch_reg(c, w[19:16]) - op2;
                c.r15 = {diff[31], diff == 32'd0, 2'b00, c.r15[27:0]};
              end
              default: begin
                r.st = ST_BADOP;
                ok = 1'b0;
              end
            endcase
            // commit the result register; r15 is replaced whole
            if (ok && w[24:21] != OPC_CMP) begin
              if (rd == REG_PC) c.r15 = val;
              else c.gpr[rd] = val;
            end
          end
          if (!ok) zero_check = 1'b0;
        end else begin
          r.st = ST_BADINSTR;
          zero_check = 1'b0;
        end
      end

      if (zero_check && c.r15 == 32'd0) r.st = ST_ZERO;
      if (r.st >= ST_EXIT) c.halted = 1'b1;
    end
    r.fetch_addr = c.r15[FETCH_BITS-1:0];
    return r;
  endfunction

  // Draw an instruction from the encodings the core runs without faulting
  function automatic logic [31:0] make_legal_instr();
    logic [31:0] w;
    logic [3:0]  cond, opc;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 50) cond = COND_AL;
    else if (pick < 70) cond = COND_EQ;
    else if (pick < 90) cond = COND_NE;
    else cond = COND_NV;
    case ($urandom_range(3))
      0: opc = OPC_MOV;
      1: opc = OPC_CMP;
      2: opc = OPC_ADD;
      default: opc = OPC_SUB;
    endcase
    pick = $urandom_range(99);
    if (pick < 35) begin
      w = enc_dp_imm(cond, opc, 4'($urandom), 4'($urandom), 4'($urandom), 8'($urandom));
      w[20] = 1'($urandom);
    end else if (pick < 60) begin
      w = enc_dp_reg(cond, opc, 4'($urandom), 4'($urandom), 5'($urandom), SHIFT_LSL,
                     1'($urandom), 4'($urandom));
      w[20] = 1'($urandom);
    end else if (pick < 80) begin
      w = enc_branch(cond, 1'($urandom), 24'($urandom));
    end else begin
      w = enc_swi(cond, $urandom_range(1) ? SWI_WRCH : SWI_NEWLINE);
    end
    return w;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Predict the beat, then drive it until the core takes it
  task automatic send_instr(input logic [31:0] w);
    result_t r;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    r = execute_instr(w, arch_state);
    pending_results.push_back(r);
    in_valid <= 1'b1;
    instruction_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Directed: immediates, shifts, flags, conditions, branches, console output
  task automatic test_directed_ops();
    in_idle_pct = 38;
    out_stall_pct = 80;
    send_instr(enc_dp_imm(COND_AL, OPC_MOV, 4'd0, 4'd0, 4'h0, 8'h41));
    send_instr(enc_swi(COND_AL, SWI_WRCH));
    send_instr(enc_swi(COND_AL, SWI_NEWLINE));
    send_instr(enc_dp_imm(COND_AL, OPC_MOV, 4'd1, 4'd0, 4'h0, 8'hff));
    send_instr(enc_dp_imm(COND_AL, OPC_MOV, 4'd2, 4'd0, 4'hf, 8'hff));
    send_instr(enc_dp_imm(COND_AL, OPC_MOV, 4'd3, 4'd0, 4'h4, 8'h80));
    // bit 4 set in the register form is ignored
    send_instr(enc_dp_reg(COND_AL, OPC_MOV, 4'd4, 4'd0, 5'd31, SHIFT_LSL, 1'b1, 4'd1));
    send_instr(enc_dp_reg(COND_AL, OPC_ADD, 4'd5, 4'd4, 5'd0, SHIFT_LSL, 1'b0, 4'd3));
    send_instr(enc_dp_imm(COND_AL, OPC_SUB, 4'd6, 4'd5, 4'h0, 8'h01));
    // negative compare, then both conditions
    send_instr(enc_dp_imm(COND_AL, OPC_CMP, 4'd0, 4'd6, 4'h0, 8'h00) | 32'h0010_0000);
    send_instr(enc_dp_imm(COND_EQ, OPC_MOV, 4'd7, 4'd0, 4'h0, 8'h01));
    send_instr(enc_dp_imm(COND_NE, OPC_MOV, 4'd7, 4'd0, 4'h0, 8'h02));
    // equal compare
    send_instr(enc_dp_imm(COND_AL, OPC_CMP, 4'd0, 4'd1, 4'h0, 8'hff) | 32'h0010_0000);
    send_instr(enc_dp_imm(COND_EQ, OPC_ADD, 4'd7, 4'd7, 4'h0, 8'h01));
    send_instr(enc_dp_imm(COND_NE, OPC_ADD, 4'd7, 4'd7, 4'h0, 8'h01));
    // compare that clears both flags; all-zero and all-one words then skip
    send_instr(enc_dp_imm(COND_AL, OPC_CMP, 4'd0, 4'd1, 4'h0, 8'h01));
    send_instr(32'h0000_0000);
    send_instr(32'hffff_ffff);
    // r15 as operand carries the advanced pc and flags
    send_instr(enc_dp_reg(COND_AL, OPC_ADD, 4'd8, REG_PC, 5'd0, SHIFT_LSL, 1'b0, REG_PC));
    send_instr(enc_branch(COND_AL, 1'b1, 24'h000000));
    send_instr(enc_branch(COND_AL, 1'b0, 24'hffffff));
    send_instr(enc_branch(COND_AL, 1'b0, 24'h800000));
    send_instr(enc_branch(COND_AL, 1'b0, 24'h7fffff));
    send_instr(enc_dp_imm(COND_AL, OPC_MOV, REG_PC, 4'd0, 4'hc, 8'h01));
    send_instr(enc_dp_imm(COND_AL, OPC_MOV, 4'd0, 4'd0, 4'h0, 8'hff));
    send_instr(enc_swi(COND_AL, SWI_WRCH));
    send_instr(enc_dp_reg(COND_AL, OPC_SUB, 4'd9, 4'd0, 5'd2, SHIFT_LSL, 1'b0, REG_PC));
  endtask

  // Random legal program; any fault halts the core for good, so drop candidates that would
  task automatic test_random_program(input int count, input int in_pct, input int out_pct);
    logic [31:0] w;
    core_t       trial;
    result_t     r;
    in_idle_pct = in_pct;
    out_stall_pct = out_pct;
    repeat (count) begin
      do begin
        w = make_legal_instr();
        trial = arch_state;
        r = execute_instr(w, trial);
      end while (r.st >= ST_EXIT);
      send_instr(w);
    end
  endtask

  // End the program with one randomly chosen halting case, then check the halted state
  task automatic test_fault_halt();
    fault_kind_t kind;
    logic [31:0] w;
    logic [23:0] num;
    logic [3:0]  opc;
    logic [2:0]  cls;
    in_idle_pct = 20;
    out_stall_pct = 50;
    kind = fault_kind_t'($urandom_range(7));
    w = $urandom;
    case (kind)
      FLT_EXIT: w = enc_swi(COND_AL, SWI_EXIT);
      FLT_BAD_COND: w[31:28] = 4'($urandom_range(2, 13));
      FLT_BAD_SWI: begin
        do num = 24'($urandom);
        while (num == SWI_WRCH || num == SWI_NEWLINE || num == SWI_EXIT);
        w = enc_swi(COND_AL, num);
      end
      FLT_BAD_SHIFT:
        w = enc_dp_reg(COND_AL, OPC_MOV, 4'd1, 4'd0, 5'($urandom), 2'($urandom_range(1, 3)),
                       1'($urandom), 4'($urandom));
      FLT_BAD_OP: begin
        do opc = 4'($urandom);
        while (opc == OPC_MOV || opc == OPC_CMP || opc == OPC_ADD || opc == OPC_SUB);
        w = enc_dp_imm(COND_AL, opc, 4'($urandom), 4'($urandom), 4'($urandom), 8'($urandom));
      end
      FLT_BAD_INSTR: begin
        do cls = 3'($urandom_range(2, 7));
        while (cls == CLS_BRANCH);
        w[31:25] = {COND_AL, cls};
        if (cls == 3'h7) w[24] = 1'b0;
      end
      FLT_PC_ZERO: w = enc_dp_imm(COND_AL, OPC_MOV, REG_PC, 4'd0, 4'h0, 8'h00);
      default: begin
        // pc wraps to zero on the fetch step of a write-char; the char still comes out
        send_instr(enc_dp_imm(COND_AL, OPC_MOV, 4'd13, 4'd0, 4'h0, 8'h00));
        send_instr(enc_dp_imm(COND_AL, OPC_SUB, REG_PC, 4'd13, 4'h0, 8'h04));
        w = enc_swi(COND_AL, SWI_WRCH);
      end
    endcase
    send_instr(w);
    repeat (4) send_instr($urandom);
  endtask

  // Receiver back-pressure
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none got status %0d", $time, status);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("next_fetch_address", 32'(want.fetch_addr), 32'(next_fetch_address));
        check_field("char_valid", 32'(want.chr_valid), 32'(char_valid));
        check_field("char_value", 32'(want.chr), 32'(char_value));
        check_field("exit_code", 32'(want.exit_val), 32'(exit_code));
        check_field("status", 32'(want.st), 32'(status));
      end
    end
  end

  // Abort when no beat moves on either side for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed_ops();
    test_random_program(375, 38, 80);
    test_random_program(375, 80, 38);
    test_random_program(375, 0, 0);
    test_fault_halt();
    in_valid <= 1'b0;
    // drain, then hold for stray beats
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// File: arm_subset_instruction_executor.f
design/ase_pkg.sv
design/ase_regfile.sv
design/arm_subset_instruction_executor.sv
tb/tb_top.sv
